// ----- sv/sha256_hash_engine_macros.svh -----
// Assertion helpers for the SHA-256 engine
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SHA_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define SHA_ASSERT_IMPL(label, clk, rst_n, prop)
`define SHA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- sv/sha_pkg.sv -----
`timescale 1ns / 1ps
package sha_pkg;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha_req_t;

    localparam logic [31:0] INIT_WORDS [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] ROUND_CONSTS [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LEN_WORD_HI = 4'd14;
    localparam logic [3:0] LEN_WORD_LO = 4'd15;
    localparam logic [5:0] LEN_POS = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ----- sv/sha_front.sv -----
`timescale 1ns / 1ps
// Input side: drops empty non-final requests, queues the rest
module sha_front
    import sha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  sha_req_t in_req,
    output logic     q_valid,
    input  logic     q_pop,
    output sha_req_t q_req
);
    sha_req_t         mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_reg, rd_reg;
    logic [QAW:0]     cnt_reg;
    logic             push;

    assign in_stall = (cnt_reg == (QAW+1)'(QDEPTH));
    assign push = in_valid && !in_stall && (in_req.has_byte || in_req.end_of_message);
    assign q_valid = (cnt_reg != '0);
    assign q_req = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop && q_valid)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(q_pop && q_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_req;
        end
    end
endmodule

// ----- sv/sha_back.sv -----
`timescale 1ns / 1ps
// Block assembly, padding, 64-round compression and digest output
module sha_back
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  sha_req_t    q_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ROUND, S_FOLD, S_EMIT
    } state_t;

    state_t       state_reg;
    logic [31:0]  blk_reg [16];      // block as words, doubles as schedule window
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [5:0]   rnd_reg;
    logic         fin_reg;          // finishing: padding block still pending
    logic         extra_reg;        // second padding block still to run
    logic [2:0]   idx_reg;
    // marks that the running block is the last block of a message
    logic         done_blk_reg;

    logic [31:0]  w, w_new, s0, s1, ch, maj, t1, t2, wm2, wm15;
    logic [3:0]   ti;

    assign ti = rnd_reg[3:0];
    assign wm2 = blk_reg[ti - 4'd2];
    assign wm15 = blk_reg[ti - 4'd15];
    assign w_new = (rotr(wm2, 17) ^ rotr(wm2, 19) ^ (wm2 >> 10)) + blk_reg[ti - 4'd7]
        + (rotr(wm15, 7) ^ rotr(wm15, 18) ^ (wm15 >> 3)) + blk_reg[ti];
    assign w = (rnd_reg < 6'd16) ? blk_reg[ti] : w_new;
    assign s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1 = v_reg[7] + s1 + ch + ROUND_CONSTS[rnd_reg] + w;
    assign s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2 = s0 + maj;

    assign q_pop = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index = idx_reg;
    assign last_word = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            extra_reg <= 1'b0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_WORDS[i];
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_req.has_byte)
                        begin
                            blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= q_req.data_byte;
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 64'd8;
                        end
                        fin_reg <= q_req.end_of_message;
                        if (q_req.has_byte && fill_reg == 6'd63)
                        begin
                            state_reg <= S_ROUND;
                            rnd_reg   <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                        end
                        else if (q_req.end_of_message)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // pad byte at fill position, zero the rest
                    for (int b = 0; b < 64; b++)
                    begin
                        if (6'(b) == fill_reg)
                        begin
                            blk_reg[4'(b / 4)][8*(3-b%4) +: 8] <= PAD_BYTE;
                        end
                        else if (6'(b) > fill_reg)
                        begin
                            blk_reg[4'(b / 4)][8*(3-b%4) +: 8] <= 8'h00;
                        end
                    end
                    if (fill_reg < LEN_POS)
                    begin
                        blk_reg[LEN_WORD_HI] <= len_reg[63:32];
                        blk_reg[LEN_WORD_LO] <= len_reg[31:0];
                        extra_reg <= 1'b0;
                    end
                    else
                    begin
                        extra_reg <= 1'b1;
                    end
                    fin_reg   <= 1'b0;
                    rnd_reg   <= '0;
                    state_reg <= S_ROUND;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
                S_ROUND:
                begin
                    if (rnd_reg >= 6'd16)
                    begin
                        blk_reg[ti] <= w_new;
                    end
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    rnd_reg  <= '0;
                    fill_reg <= '0;
                    if (fin_reg)
                    begin
                        state_reg <= S_PAD;
                    end
                    else if (extra_reg)
                    begin
                        // length-only block
                        extra_reg <= 1'b0;
                        for (int i = 0; i < 14; i++)
                        begin
                            blk_reg[i] <= '0;
                        end
                        blk_reg[LEN_WORD_HI] <= len_reg[63:32];
                        blk_reg[LEN_WORD_LO] <= len_reg[31:0];
                        state_reg <= S_ROUND;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= h_reg[i] + v_reg[i];
                        end
                    end
                    else if (done_blk_reg)
                    begin
                        // a fold that closed the final block goes to output
                        state_reg <= S_EMIT;
                        idx_reg   <= '0;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            state_reg <= S_IDLE;
                            len_reg   <= '0;
                            fill_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_WORDS[i];
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_blk_reg <= 1'b0;
        end
        else if (state_reg == S_PAD)
        begin
            done_blk_reg <= (fill_reg < LEN_POS);
        end
        else if (state_reg == S_FOLD && extra_reg)
        begin
            done_blk_reg <= 1'b1;
        end
        else if (state_reg == S_EMIT)
        begin
            done_blk_reg <= 1'b0;
        end
    end
endmodule

// ----- sv/sha256_hash_engine.sv -----
`timescale 1ns / 1ps
// Streaming SHA-256: one message byte per request, digest given as eight 32-bit
// words, most significant first, after a request with end_of_message set. A
// four-entry request queue holds up to four requests while a block compresses.
// Bytes are loaded from the queue into the block; after the 64th byte the
// compression runs one round per cycle, 64 rounds followed by a fold, and no
// new byte is taken until the block is done. Finishing takes a padding step
// and one or two further blocks, then eight output words, which out_stall can
// hold.
`include "sha256_hash_engine_macros.svh"
module sha256_hash_engine
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    sha_req_t in_req, q_req;
    logic     q_valid, q_pop;

    assign in_req = '{data_byte: data_byte, has_byte: has_byte,
                      end_of_message: end_of_message};

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
    );

    sha_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
        .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

    `SHA_ASSERT_IMPL(a_last_idx, clk, rst_n, (out_valid && last_word) |-> (word_index == 3'd7))
    `SHA_ASSERT_IMPL(a_hold, clk, rst_n, (out_valid && out_stall) |=> $stable(digest_word))
    `SHA_ASSERT_NEVER(a_no_pop_busy, clk, rst_n, out_valid && q_pop)
endmodule
